// ----- src/cmts_pkg.sv -----
// package for the c-minus token scanner: transaction types, scanner state,
// token and error codes, character constants and the per-character helper functions
// no dependencies
package cmts_pkg;

   localparam int MAX_LEXEME  = 40;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      ST_START  = 4'd0,
      ST_SLASH  = 4'd1,
      ST_COMMENT = 4'd2,
      ST_CSTAR  = 4'd3,
      ST_NUM    = 4'd4,
      ST_NUMERR = 4'd5,
      ST_ID     = 4'd6,
      ST_ASSIGN = 4'd7,
      ST_NE     = 4'd8,
      ST_LE     = 4'd9,
      ST_GE     = 4'd10
   } scan_state_type;

   localparam logic [4:0] TK_ENDFILE = 5'd0;
   localparam logic [4:0] TK_ERROR   = 5'd1;
   localparam logic [4:0] TK_ELSE    = 5'd2;
   localparam logic [4:0] TK_IF      = 5'd3;
   localparam logic [4:0] TK_INT     = 5'd4;
   localparam logic [4:0] TK_RETURN  = 5'd5;
   localparam logic [4:0] TK_VOID    = 5'd6;
   localparam logic [4:0] TK_WHILE   = 5'd7;
   localparam logic [4:0] TK_ID      = 5'd8;
   localparam logic [4:0] TK_NUM     = 5'd9;
   localparam logic [4:0] TK_ASSIGN  = 5'd10;
   localparam logic [4:0] TK_EQ      = 5'd11;
   localparam logic [4:0] TK_NE      = 5'd12;
   localparam logic [4:0] TK_LT      = 5'd13;
   localparam logic [4:0] TK_LE      = 5'd14;
   localparam logic [4:0] TK_GT      = 5'd15;
   localparam logic [4:0] TK_GE      = 5'd16;
   localparam logic [4:0] TK_PLUS    = 5'd17;
   localparam logic [4:0] TK_MINUS   = 5'd18;
   localparam logic [4:0] TK_TIMES   = 5'd19;
   localparam logic [4:0] TK_OVER    = 5'd20;
   localparam logic [4:0] TK_LPAREN  = 5'd21;
   localparam logic [4:0] TK_RPAREN  = 5'd22;
   localparam logic [4:0] TK_LBRACKET = 5'd23;
   localparam logic [4:0] TK_RBRACKET = 5'd24;
   localparam logic [4:0] TK_LBRACE  = 5'd25;
   localparam logic [4:0] TK_RBRACE  = 5'd26;
   localparam logic [4:0] TK_SEMI    = 5'd27;
   localparam logic [4:0] TK_COMMA   = 5'd28;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
   localparam logic [2:0] ERR_BANG      = 3'd2;
   localparam logic [2:0] ERR_BAD_NUM   = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED  = 3'd4;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_LESS     = 8'h3C;
   localparam logic [7:0] CH_EQUAL    = 8'h3D;
   localparam logic [7:0] CH_GREATER  = 8'h3E;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;

   // keyword text, first character in the low byte
   localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
   localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
   localparam logic [47:0] KW_INT    = 48'h0000_0074_6E69;
   localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;
   localparam logic [47:0] KW_VOID   = 48'h0000_6469_6F76;
   localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;

   localparam logic [5:0] LEX_CAP = 6'(MAX_LEXEME);

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [2:0]  error_kind;
      logic [5:0]  lexeme_length;
      logic [15:0] line_number;
      logic [31:0] number_value;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      scan_state_type scan_state;
      logic [5:0]     lexeme_count;
      logic [47:0]    keyword_chars;
      logic [31:0]    number_accumulator;
      logic [15:0]    line_count;
      logic [15:0]    comment_start_line;
   } scan_regs_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic scan_regs_type keep_char(input scan_regs_type r_in,
                                               input logic [7:0] c);
      scan_regs_type r;
      r = r_in;
      for (int i = 0; i < 6; i++) begin
         if (r_in.lexeme_count == 6'(i)) begin
            r.keyword_chars[8*i +: 8] = c;
         end
      end
      if (r_in.lexeme_count <= LEX_CAP) begin
         r.lexeme_count = r_in.lexeme_count + 6'd1;
      end
      return r;
   endfunction

   function automatic scan_regs_type add_digit(input scan_regs_type r_in,
                                               input logic [7:0] c);
      scan_regs_type r;
      logic [35:0]   prod;
      r = r_in;
      prod = ({4'b0, r_in.number_accumulator} << 3) + ({4'b0, r_in.number_accumulator} << 1)
           + {32'b0, c[3:0]};
      r.number_accumulator = (prod[35:32] != 4'b0) ? 32'hFFFF_FFFF : prod[31:0];
      return r;
   endfunction

   function automatic logic [4:0] lookup_id(input logic [5:0] len, input logic [47:0] kw);
      logic [4:0] kind;
      kind = TK_ID;
      if (len == 6'd4 && kw == KW_ELSE) kind = TK_ELSE;
      if (len == 6'd2 && kw == KW_IF) kind = TK_IF;
      if (len == 6'd3 && kw == KW_INT) kind = TK_INT;
      if (len == 6'd6 && kw == KW_RETURN) kind = TK_RETURN;
      if (len == 6'd4 && kw == KW_VOID) kind = TK_VOID;
      if (len == 6'd5 && kw == KW_WHILE) kind = TK_WHILE;
      return kind;
   endfunction

   function automatic rsp_type make_token(input logic [4:0] kind, input logic [2:0] err,
                                          input logic [5:0] len, input logic [15:0] line,
                                          input logic [31:0] val);
      rsp_type t;
      t.token_kind    = kind;
      t.error_kind    = err;
      t.lexeme_length = len;
      t.line_number   = line;
      t.number_value  = val;
      t.last_of_run   = 1'b0;
      return t;
   endfunction

endpackage

// ----- src/cmts_step.sv -----
// one character step of the scanner: next scanner state and up to two tokens
// depends on cmts_pkg
module cmts_step (
   input  cmts_pkg::scan_regs_type cur,
   input  cmts_pkg::req_type       req,
   output cmts_pkg::scan_regs_type nxt,
   output cmts_pkg::rsp_type       tok0,
   output logic                    tok0_valid,
   output cmts_pkg::rsp_type       tok1,
   output logic                    tok1_valid
);

   cmts_pkg::scan_regs_type r;
   cmts_pkg::rsp_type       ta;
   cmts_pkg::rsp_type       tb;
   cmts_pkg::rsp_type       t0;
   cmts_pkg::rsp_type       t1;
   logic                    va;
   logic                    vb;
   logic                    redo;
   logic                    eof;
   logic [7:0]              c;
   logic [4:0]              base_kind;
   logic [4:0]              eq_kind;

   assign eof = req.end_of_input;
   assign c   = req.char_code;

   always_comb begin
      case (cur.scan_state)
         cmts_pkg::ST_NE: begin
            base_kind = cmts_pkg::TK_NE;
            eq_kind   = cmts_pkg::TK_NE;
         end
         cmts_pkg::ST_LE: begin
            base_kind = cmts_pkg::TK_LT;
            eq_kind   = cmts_pkg::TK_LE;
         end
         cmts_pkg::ST_GE: begin
            base_kind = cmts_pkg::TK_GT;
            eq_kind   = cmts_pkg::TK_GE;
         end
         default: begin
            base_kind = cmts_pkg::TK_ASSIGN;
            eq_kind   = cmts_pkg::TK_EQ;
         end
      endcase
   end

   always_comb begin
      r    = cur;
      ta   = '0;
      tb   = '0;
      va   = 1'b0;
      vb   = 1'b0;
      redo = 1'b0;

      unique case (cur.scan_state) inside
         cmts_pkg::ST_SLASH: begin
            if (!eof && c == cmts_pkg::CH_STAR) begin
               r.scan_state         = cmts_pkg::ST_COMMENT;
               r.comment_start_line = cur.line_count;
            end else begin
               va   = 1'b1;
               ta   = cmts_pkg::make_token(cmts_pkg::TK_OVER, cmts_pkg::ERR_NONE, 6'd1,
                                           cur.line_count, 32'd0);
               redo = 1'b1;
            end
         end
         cmts_pkg::ST_COMMENT, cmts_pkg::ST_CSTAR: begin
            if (eof) begin
               va           = 1'b1;
               ta           = cmts_pkg::make_token(cmts_pkg::TK_ENDFILE,
                                                   cmts_pkg::ERR_UNCLOSED, 6'd0,
                                                   cur.comment_start_line, 32'd0);
               r.scan_state = cmts_pkg::ST_START;
            end else if (c == cmts_pkg::CH_STAR) begin
               r.scan_state = cmts_pkg::ST_CSTAR;
            end else if (cur.scan_state == cmts_pkg::ST_CSTAR && c == cmts_pkg::CH_SLASH) begin
               r.scan_state = cmts_pkg::ST_START;
            end else begin
               r.scan_state = cmts_pkg::ST_COMMENT;
            end
         end
         cmts_pkg::ST_ASSIGN, cmts_pkg::ST_NE, cmts_pkg::ST_LE, cmts_pkg::ST_GE: begin
            if (!eof && c == cmts_pkg::CH_EQUAL) begin
               va                   = 1'b1;
               ta                   = cmts_pkg::make_token(eq_kind, cmts_pkg::ERR_NONE, 6'd2,
                                                           cur.line_count, 32'd0);
               r.scan_state         = cmts_pkg::ST_START;
               r.lexeme_count       = '0;
               r.keyword_chars      = '0;
               r.number_accumulator = '0;
            end else begin
               va = 1'b1;
               if (cur.scan_state == cmts_pkg::ST_NE) begin
                  ta = cmts_pkg::make_token(cmts_pkg::TK_ERROR, cmts_pkg::ERR_BANG, 6'd1,
                                            cur.line_count, 32'd0);
               end else begin
                  ta = cmts_pkg::make_token(base_kind, cmts_pkg::ERR_NONE, 6'd1,
                                            cur.line_count, 32'd0);
               end
               redo = 1'b1;
            end
         end
         cmts_pkg::ST_NUM: begin
            if (!eof && cmts_pkg::is_digit(c)) begin
               r = cmts_pkg::add_digit(cmts_pkg::keep_char(cur, c), c);
            end else if (!eof && cmts_pkg::is_letter(c)) begin
               r            = cmts_pkg::keep_char(cur, c);
               r.scan_state = cmts_pkg::ST_NUMERR;
            end else begin
               va   = 1'b1;
               ta   = cmts_pkg::make_token(cmts_pkg::TK_NUM, cmts_pkg::ERR_NONE,
                                           cur.lexeme_count, cur.line_count,
                                           cur.number_accumulator);
               redo = 1'b1;
            end
         end
         cmts_pkg::ST_NUMERR: begin
            if (!eof && (cmts_pkg::is_digit(c) || cmts_pkg::is_letter(c))) begin
               r = cmts_pkg::keep_char(cur, c);
            end else begin
               va   = 1'b1;
               ta   = cmts_pkg::make_token(cmts_pkg::TK_ERROR, cmts_pkg::ERR_BAD_NUM,
                                           cur.lexeme_count, cur.line_count, 32'd0);
               redo = 1'b1;
            end
         end
         cmts_pkg::ST_ID: begin
            if (!eof && (cmts_pkg::is_digit(c) || cmts_pkg::is_letter(c))) begin
               r = cmts_pkg::keep_char(cur, c);
            end else begin
               va   = 1'b1;
               ta   = cmts_pkg::make_token(cmts_pkg::lookup_id(cur.lexeme_count,
                                                                cur.keyword_chars),
                                           cmts_pkg::ERR_NONE, cur.lexeme_count,
                                           cur.line_count, 32'd0);
               redo = 1'b1;
            end
         end
         default: begin
            redo = 1'b1;
         end
      endcase

      // start-state scan of the current or lookahead character
      if (redo) begin
         r.scan_state         = cmts_pkg::ST_START;
         r.lexeme_count       = '0;
         r.keyword_chars      = '0;
         r.number_accumulator = '0;
         if (eof) begin
            vb = 1'b1;
            tb = cmts_pkg::make_token(cmts_pkg::TK_ENDFILE, cmts_pkg::ERR_NONE, 6'd0,
                                      cur.line_count, 32'd0);
         end else if (cmts_pkg::is_digit(c)) begin
            r            = cmts_pkg::add_digit(cmts_pkg::keep_char(r, c), c);
            r.scan_state = cmts_pkg::ST_NUM;
         end else if (cmts_pkg::is_letter(c)) begin
            r            = cmts_pkg::keep_char(r, c);
            r.scan_state = cmts_pkg::ST_ID;
         end else begin
            case (c) inside
               cmts_pkg::CH_EQUAL: begin
                  r            = cmts_pkg::keep_char(r, c);
                  r.scan_state = cmts_pkg::ST_ASSIGN;
               end
               cmts_pkg::CH_BANG: begin
                  r            = cmts_pkg::keep_char(r, c);
                  r.scan_state = cmts_pkg::ST_NE;
               end
               cmts_pkg::CH_LESS: begin
                  r            = cmts_pkg::keep_char(r, c);
                  r.scan_state = cmts_pkg::ST_LE;
               end
               cmts_pkg::CH_GREATER: begin
                  r            = cmts_pkg::keep_char(r, c);
                  r.scan_state = cmts_pkg::ST_GE;
               end
               cmts_pkg::CH_SLASH: begin
                  r.scan_state = cmts_pkg::ST_SLASH;
               end
               cmts_pkg::CH_SPACE, cmts_pkg::CH_TAB, cmts_pkg::CH_LF: begin
               end
               default: begin
                  vb = 1'b1;
                  tb = cmts_pkg::make_token(cmts_pkg::TK_ERROR, cmts_pkg::ERR_UNKNOWN, 6'd1,
                                            cur.line_count, 32'd0);
                  case (c)
                     cmts_pkg::CH_PLUS:     tb = cmts_pkg::make_token(cmts_pkg::TK_PLUS,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_MINUS:    tb = cmts_pkg::make_token(cmts_pkg::TK_MINUS,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_STAR:     tb = cmts_pkg::make_token(cmts_pkg::TK_TIMES,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_LPAREN:   tb = cmts_pkg::make_token(cmts_pkg::TK_LPAREN,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_RPAREN:   tb = cmts_pkg::make_token(cmts_pkg::TK_RPAREN,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_LBRACKET: tb = cmts_pkg::make_token(cmts_pkg::TK_LBRACKET,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_RBRACKET: tb = cmts_pkg::make_token(cmts_pkg::TK_RBRACKET,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_LBRACE:   tb = cmts_pkg::make_token(cmts_pkg::TK_LBRACE,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_RBRACE:   tb = cmts_pkg::make_token(cmts_pkg::TK_RBRACE,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_SEMI:     tb = cmts_pkg::make_token(cmts_pkg::TK_SEMI,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     cmts_pkg::CH_COMMA:    tb = cmts_pkg::make_token(cmts_pkg::TK_COMMA,
                                               cmts_pkg::ERR_NONE, 6'd1, cur.line_count, 32'd0);
                     default: begin
                     end
                  endcase
               end
            endcase
         end
      end

      // line advances after the tokens of this character
      if (!eof && c == cmts_pkg::CH_LF && cur.line_count != 16'hFFFF) begin
         r.line_count = cur.line_count + 16'd1;
      end
   end

   always_comb begin
      t0             = va ? ta : tb;
      t1             = tb;
      t0.last_of_run = !(va && vb);
      t1.last_of_run = 1'b1;
   end

   assign nxt        = r;
   assign tok0       = t0;
   assign tok0_valid = va || vb;
   assign tok1       = t1;
   assign tok1_valid = va && vb;

endmodule

// ----- src/cmts_out_queue.sv -----
// result queue of the token scanner: takes up to two tokens a cycle, gives one
// depends on cmts_pkg
module cmts_out_queue (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        push0,
   input  cmts_pkg::rsp_type                           data0,
   input  logic                                        push1,
   input  cmts_pkg::rsp_type                           data1,
   input  logic                                        pop,
   output cmts_pkg::rsp_type                           head,
   output logic [$clog2(cmts_pkg::QUEUE_DEPTH+1)-1:0]  count
);

   localparam int PTR_W = $clog2(cmts_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cmts_pkg::QUEUE_DEPTH+1);

   cmts_pkg::rsp_type  entry_ff [cmts_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      count_in    = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wr_ptr_next] <= data1;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ----- src/c_minus_token_scanner.sv -----
// c-minus token scanner top level: input register, character step, result queue
// depends on cmts_pkg, cmts_step, cmts_out_queue
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   cmts_pkg::req_type (one character or end mark)
//   rsp       out        rsp_valid/rsp_stall   cmts_pkg::rsp_type (one token)
//
// one character is taken per cycle unless req_stall is high; tokens pass the input register
// and result queue to rsp; a character that ends a token and is itself a one-character token
// gives two tokens, which leave the four-entry queue singly; drain sets the sustained rate
// req_stall is raised while a character waits in the input register and the queue holds
// more than two tokens
// reset clears the scanner state (line counter to one), the input register and the queue
module c_minus_token_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cmts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cmts_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(cmts_pkg::QUEUE_DEPTH+1);

   cmts_pkg::req_type       req_ff;
   logic                    req_valid_ff;
   cmts_pkg::scan_regs_type scan_ff;
   cmts_pkg::scan_regs_type scan_in;
   cmts_pkg::rsp_type       tok0;
   cmts_pkg::rsp_type       tok1;
   logic                    tok0_valid;
   logic                    tok1_valid;
   logic                    step_fire;
   logic                    req_take;
   logic                    rsp_take;
   logic [CNT_W-1:0]        q_count;

   assign step_fire = req_valid_ff && (q_count <= CNT_W'(cmts_pkg::QUEUE_DEPTH - 2));
   assign req_stall = req_valid_ff && !step_fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = q_count != '0;
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (step_fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.scan_state         <= cmts_pkg::ST_START;
         scan_ff.lexeme_count       <= '0;
         scan_ff.keyword_chars      <= '0;
         scan_ff.number_accumulator <= '0;
         scan_ff.line_count         <= 16'd1;
         scan_ff.comment_start_line <= '0;
      end else if (step_fire) begin
         scan_ff <= scan_in;
      end
   end

   cmts_step u_step (
      .cur        (scan_ff),
      .req        (req_ff),
      .nxt        (scan_in),
      .tok0       (tok0),
      .tok0_valid (tok0_valid),
      .tok1       (tok1),
      .tok1_valid (tok1_valid)
   );

   cmts_out_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push0 (step_fire && tok0_valid),
      .data0 (tok0),
      .push1 (step_fire && tok1_valid),
      .data1 (tok1),
      .pop   (rsp_take),
      .head  (rsp_data),
      .count (q_count)
   );

endmodule

// ----- src/cmts_checker.sv -----
// port checker for the c-minus token scanner, bound to the top level
// depends on cmts_pkg and c_minus_token_scanner
module cmts_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cmts_pkg::rsp_type rsp_data
);

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("token shown right after reset");

   a_error_kind_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_kind != cmts_pkg::ERR_NONE |->
         rsp_data.token_kind == cmts_pkg::TK_ERROR ||
         rsp_data.token_kind == cmts_pkg::TK_ENDFILE)
      else $error("error kind on a regular token");

   a_value_only_on_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_kind != cmts_pkg::TK_NUM |-> rsp_data.number_value == 32'd0)
      else $error("number value on a non-number token");

endmodule

bind c_minus_token_scanner cmts_checker u_checker (.*);
